FILE: rtl/ppa_pkg.sv
// shared constants and control types for the polygon perimeter/area block
package ppa_pkg;
  localparam int MAX_VERTICES_DEF = 128;
  localparam int FRAC_BITS_DEF    = 8;
  localparam int COORD_W = 16;
  localparam int ACC_W   = 48;
  localparam int CNT_W   = 8;
  localparam int PROD_W  = 128;
  localparam int ROOT_W  = 64;

  // square root operand select
  localparam logic [1:0] SRC_EDGE   = 2'd0;
  localparam logic [1:0] SRC_RADIUS = 2'd1;
  localparam logic [1:0] SRC_HERON  = 2'd2;

  typedef struct packed {
    logic       load;
    logic       sqrt_start;
    logic [1:0] sqrt_src;
    logic       save_edge;
    logic       save_radius;
    logic       heron_mul;
    logic       commit;
  } ppa_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic mul_done;
    logic first_vtx;
    logic do_area;
    logic last_vtx;
  } ppa_sts_t;
endpackage

FILE: rtl/polygon_perimeter_area_top.sv
// top level of the polygon perimeter and fan area block
// Vertices enter one item at a time on in_valid/in_ready with x, y and a
// last flag. The first vertex goes straight to the commit step; later ones run two
// 64-step square roots (edge and radius), and from the third vertex on a
// 64-step heron product and a third 64-step root, all on the shared
// one-bit-a-cycle root unit and the shift-add heron multiplier.
// The last vertex drops one result item into the output register:
// perimeter, area, vertex count and an overflow flag, then the state
// returns to its reset values. A further vertex may be taken while that
// result waits; a second last vertex holds in the commit step until the
// receiver takes the first result.
// Synchronous active-low reset clears all accumulators, the counter and
// the output valid. A stalled receiver keeps out_valid and the payload.
module polygon_perimeter_area_top #(
  parameter int MAX_VERTICES = ppa_pkg::MAX_VERTICES_DEF,
  parameter int FRAC_BITS    = ppa_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [ppa_pkg::COORD_W-1:0] in_x_coord,
  input  logic signed [ppa_pkg::COORD_W-1:0] in_y_coord,
  input  logic                               in_last_vertex,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ppa_pkg::ACC_W-1:0]          out_perimeter_len,
  output logic [ppa_pkg::ACC_W-1:0]          out_area_sum,
  output logic [ppa_pkg::CNT_W-1:0]          out_vertex_total,
  output logic                               out_too_many
);
  import ppa_pkg::*;

  ppa_cmd_t cmd;
  ppa_sts_t sts;
  logic ctl_idle, in_fire, out_busy;
  logic [ACC_W-1:0] rp, ra;
  logic [CNT_W-1:0] rc;
  logic ro;

  assign out_busy = out_valid && !out_ready;
  assign in_fire  = in_valid && in_ready;

  ppa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_busy(out_busy),
    .sts(sts), .cmd(cmd), .idle(ctl_idle)
  );

  ppa_datapath #(.MAX_VERTICES(MAX_VERTICES), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_x(in_x_coord), .in_y(in_y_coord), .in_last(in_last_vertex),
    .res_perim(rp), .res_area(ra), .res_count(rc), .res_over(ro)
  );

  // ready only between vertices
  assign in_ready = ctl_idle;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.commit && sts.last_vtx) begin
        out_valid         <= 1'b1;
        out_perimeter_len <= rp;
        out_area_sum      <= ra;
        out_vertex_total  <= rc;
        out_too_many      <= ro;
      end
    end
  end

  // a result never overwrites a waiting item, no input is taken while a vertex is in work, no result has a zero count
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && sts.last_vtx) |-> !(out_valid && !out_ready))
    else $error("result overwrote a waiting item");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_ready)
    else $error("input accepted while a vertex is in work");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && sts.last_vtx) |-> (rc != '0))
    else $error("zero vertex count on result");
endmodule

FILE: rtl/ppa_ctrl.sv
// controller sequencing the edge, radius and heron square roots per vertex
module ppa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              out_busy,
  input  ppa_pkg::ppa_sts_t sts,
  output ppa_pkg::ppa_cmd_t cmd,
  output logic              idle
);
  import ppa_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EDGE = 3'd1;
  localparam logic [2:0] S_RAD  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_HER  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       started_r, started_nxt;

  // ready for a new vertex only between vertices
  assign idle = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    started_nxt = 1'b0;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = S_EDGE;
        end
      end
      S_EDGE: begin
        if (sts.first_vtx) begin
          state_nxt = S_DONE;
        end else if (!started_r) begin
          cmd.sqrt_start = 1'b1;
          cmd.sqrt_src = SRC_EDGE;
          started_nxt = 1'b1;
        end else if (sts.sqrt_done) begin
          cmd.save_edge = 1'b1;
          state_nxt = S_RAD;
        end else begin
          started_nxt = 1'b1;
        end
      end
      S_RAD: begin
        if (!started_r) begin
          cmd.sqrt_start = 1'b1;
          cmd.sqrt_src = SRC_RADIUS;
          started_nxt = 1'b1;
        end else if (sts.sqrt_done) begin
          cmd.save_radius = 1'b1;
          state_nxt = sts.do_area ? S_MUL : S_DONE;
        end else begin
          started_nxt = 1'b1;
        end
      end
      S_MUL: begin
        if (!started_r) begin
          cmd.heron_mul = 1'b1;
          started_nxt = 1'b1;
        end else if (sts.mul_done) begin
          state_nxt = S_HER;
        end else begin
          started_nxt = 1'b1;
        end
      end
      S_HER: begin
        if (!started_r) begin
          cmd.sqrt_start = 1'b1;
          cmd.sqrt_src = SRC_HERON;
          started_nxt = 1'b1;
        end else if (sts.sqrt_done) begin
          state_nxt = S_DONE;
        end else begin
          started_nxt = 1'b1;
        end
      end
      S_DONE: begin
        if (!(sts.last_vtx && out_busy)) begin
          cmd.commit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      started_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      started_r <= started_nxt;
    end
  end
endmodule

FILE: rtl/ppa_datapath.sv
// datapath: vertex registers, shared root unit, heron multiplier, accumulators
module ppa_datapath #(
  parameter int MAX_VERTICES = ppa_pkg::MAX_VERTICES_DEF,
  parameter int FRAC_BITS    = ppa_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ppa_pkg::ppa_cmd_t              cmd,
  output ppa_pkg::ppa_sts_t              sts,
  input  logic signed [ppa_pkg::COORD_W-1:0] in_x,
  input  logic signed [ppa_pkg::COORD_W-1:0] in_y,
  input  logic                           in_last,
  output logic [ppa_pkg::ACC_W-1:0]      res_perim,
  output logic [ppa_pkg::ACC_W-1:0]      res_area,
  output logic [ppa_pkg::CNT_W-1:0]      res_count,
  output logic                           res_over
);
  import ppa_pkg::*;

  // a length needs the coordinate width plus one growth bit, a sqrt(2) bit and the fraction
  localparam int LEN_W = COORD_W + 2 + FRAC_BITS;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int SC_W = $clog2(ROOT_STEPS + 1);
  localparam logic [ACC_W-1:0] SAT = {ACC_W{1'b1}};

  logic signed [COORD_W-1:0] fx_r, fy_r, px_r, py_r, cx_r, cy_r;
  logic                      last_r;
  logic [LEN_W-1:0]          prad_r, edge_r, rad_r;
  logic [ACC_W-1:0]          perim_r, area_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      over_r;

  // square root unit state
  logic [PROD_W-1:0] rem_r, num_r;
  logic [ROOT_W-1:0] root_r;
  logic [SC_W-1:0]   sc_r;
  logic              sbusy_r;

  // heron product: shift-add multiplier, 64x64
  logic [PROD_W-1:0] prod_r, mcand_r;
  logic [ROOT_W-1:0] mplier_r;
  logic [6:0]        mc_r;
  logic              mbusy_r, mphase_r;
  logic [ROOT_W-1:0] fb_fc_r, p_fa_r;

  // distance squared operands (17-bit deltas, squared in the start cycle)
  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W:0]        ax, ay;
  logic [2*COORD_W+1:0]    dsq;
  assign dx = (cmd.sqrt_src == SRC_EDGE) ? (COORD_W+1)'(cx_r) - (COORD_W+1)'(px_r)
                                         : (COORD_W+1)'(cx_r) - (COORD_W+1)'(fx_r);
  assign dy = (cmd.sqrt_src == SRC_EDGE) ? (COORD_W+1)'(cy_r) - (COORD_W+1)'(py_r)
                                         : (COORD_W+1)'(cy_r) - (COORD_W+1)'(fy_r);
  assign ax = dx[COORD_W] ? (COORD_W+1)'(-dx) : (COORD_W+1)'(dx);
  assign ay = dy[COORD_W] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);
  assign dsq = (2*COORD_W+2)'(ax * ax) + (2*COORD_W+2)'(ay * ay);

  // heron factors
  logic [LEN_W+1:0] hp, ha2, hb2, hc2, hfa, hfb, hfc;
  assign hp  = (LEN_W+2)'(prad_r) + (LEN_W+2)'(edge_r) + (LEN_W+2)'(rad_r);
  assign ha2 = {1'b0, prad_r, 1'b0};
  assign hb2 = {1'b0, edge_r, 1'b0};
  assign hc2 = {1'b0, rad_r, 1'b0};
  assign hfa = (ha2 > hp) ? '0 : hp - ha2;
  assign hfb = (hb2 > hp) ? '0 : hp - hb2;
  assign hfc = (hc2 > hp) ? '0 : hp - hc2;

  // factor pair products, each as wide as both factors together
  logic [2*LEN_W+3:0] pfa_m, fbfc_m;
  assign pfa_m  = hp * hfa;
  assign fbfc_m = hfb * hfc;

  // restoring root step, two bits of radicand per cycle
  logic [PROD_W+1:0] trial, rem_sh;
  assign rem_sh = {rem_r, num_r[PROD_W-1 -: 2]};
  assign trial  = rem_sh - {{(PROD_W-ROOT_W){1'b0}}, root_r, 2'b01};

  logic [ACC_W:0] psum, asum;
  logic [ROOT_W-1:0] hroot_sh;
  assign hroot_sh = root_r >> (FRAC_BITS + 2);
  assign psum = {1'b0, perim_r} + (ACC_W+1)'(edge_r);
  assign asum = {1'b0, area_r} + (ACC_W+1)'(hroot_sh);

  assign sts.sqrt_done = !sbusy_r;
  assign sts.mul_done  = !mbusy_r;
  assign sts.first_vtx = (cnt_r == '0);
  assign sts.do_area   = (cnt_r >= CNT_W'(2));
  assign sts.last_vtx  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_r <= '0; fy_r <= '0; px_r <= '0; py_r <= '0;
      prad_r <= '0; perim_r <= '0; area_r <= '0;
      cnt_r <= '0; over_r <= 1'b0; sbusy_r <= 1'b0; mbusy_r <= 1'b0;
      edge_r <= '0; rad_r <= '0;
    end else begin
      if (cmd.load) begin
        cx_r <= in_x; cy_r <= in_y; last_r <= in_last;
        rad_r <= '0;
        if (cnt_r == '0) begin
          fx_r <= in_x; fy_r <= in_y;
        end
      end
      // root unit
      if (cmd.sqrt_start) begin
        rem_r   <= '0;
        root_r  <= '0;
        sc_r    <= SC_W'(ROOT_STEPS);
        sbusy_r <= 1'b1;
        if (cmd.sqrt_src == SRC_HERON)
          num_r <= prod_r;
        else
          num_r <= PROD_W'(dsq) << (2 * FRAC_BITS);
      end else if (sbusy_r) begin
        num_r <= num_r << 2;
        if (!trial[PROD_W+1]) begin
          rem_r  <= trial[PROD_W-1:0];
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh[PROD_W-1:0];
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
        sc_r <= sc_r - SC_W'(1);
        if (sc_r == SC_W'(1)) sbusy_r <= 1'b0;
      end
      if (cmd.save_edge) edge_r <= root_r[LEN_W-1:0];
      if (cmd.save_radius) rad_r <= root_r[LEN_W-1:0];
      // multiplier: first form two 64-bit products of factors, then the wide product
      if (cmd.heron_mul) begin
        p_fa_r   <= ROOT_W'(pfa_m);
        fb_fc_r  <= ROOT_W'(fbfc_m);
        mphase_r <= 1'b0;
        mbusy_r  <= 1'b1;
      end else if (mbusy_r) begin
        if (!mphase_r) begin
          mcand_r  <= PROD_W'(p_fa_r);
          mplier_r <= fb_fc_r;
          prod_r   <= '0;
          mc_r     <= 7'(ROOT_W);
          mphase_r <= 1'b1;
        end else begin
          if (mplier_r[0]) prod_r <= prod_r + mcand_r;
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          mc_r     <= mc_r - 7'd1;
          if (mc_r == 7'd1) mbusy_r <= 1'b0;
        end
      end
      // commit vertex
      if (cmd.commit) begin
        if (last_r) begin
          fx_r <= '0; fy_r <= '0; px_r <= '0; py_r <= '0; prad_r <= '0;
          perim_r <= '0; area_r <= '0; cnt_r <= '0; over_r <= 1'b0;
        end else begin
          px_r <= cx_r; py_r <= cy_r; prad_r <= rad_r;
          if (cnt_r != '0) perim_r <= psum[ACC_W] ? SAT : psum[ACC_W-1:0];
          if (sts.do_area) area_r <= asum[ACC_W] ? SAT : asum[ACC_W-1:0];
          if (cnt_r >= CNT_W'(MAX_VERTICES)) over_r <= 1'b1;
          else cnt_r <= cnt_r + CNT_W'(1);
        end
      end
    end
  end

  // result values formed from state as of the last vertex
  logic [ACC_W-1:0] pf, af;
  logic [ACC_W:0]   fin;
  assign pf  = (cnt_r != '0) ? (psum[ACC_W] ? SAT : psum[ACC_W-1:0]) : perim_r;
  assign af  = sts.do_area ? (asum[ACC_W] ? SAT : asum[ACC_W-1:0]) : area_r;
  assign fin = {1'b0, pf} + (ACC_W+1)'(rad_r);
  assign res_perim = fin[ACC_W] ? SAT : fin[ACC_W-1:0];
  assign res_area  = af;
  assign res_count = (cnt_r >= CNT_W'(MAX_VERTICES)) ? cnt_r : cnt_r + CNT_W'(1);
  assign res_over  = over_r || (cnt_r >= CNT_W'(MAX_VERTICES));
endmodule
